// File: hdl/dotq_pkg.sv
// Shared types and codes for the deadline-ordered timer queue.
// Depends on nothing; used by the top level and the testbench, not by dotq_ram.
package dotq_pkg;

   localparam int DEPTH_DEF = 16;
   localparam int ID_W      = 4;
   localparam int NUM_IDS   = 16;
   localparam int TIME_W    = 64;
   localparam int OP_W      = 2;
   localparam int STAT_W    = 3;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE    = 3'd0;
   localparam logic [STAT_W-1:0] STAT_EXPIRED = 3'd1;
   localparam logic [STAT_W-1:0] STAT_NONE    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
   localparam logic [STAT_W-1:0] STAT_DUP     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_ABSENT  = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ID_W-1:0]   entry_id;
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [ID_W-1:0]   result_id;
      logic              last;
   } rsp_type;

endpackage

// File: hdl/dotq_ram.sv
// Single-port-write, single-port-read memory with registered read data.
// Holds the queue order and the per-id deadlines; no package dependency.
module dotq_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// File: hdl/deadline_ordered_timer_queue.sv
// Top level of the deadline-ordered timer queue: sequencer over two memories.
// Depends on dotq_pkg and dotq_ram.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | dotq_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_ready  | dotq_pkg::rsp_type
//
// Queue order lives in a ring memory, deadlines in a memory indexed by id; both
// reads are registered, so a sorted insert reads the order entry and then its deadline
// for each entry it moves past, S_INS_PUT placing it when it passes every entry. Remove
// scans from the head and shifts the rest back; check reads and compares from the head.
// Reset clears the pending flags, count and ring pointers at once; no clearing pass.
// A held result beat stalls only steps that must send a beat; req is taken in idle.
module deadline_ordered_timer_queue #(
   parameter int DEPTH = dotq_pkg::DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dotq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dotq_pkg::rsp_type rsp_data
);
   import dotq_pkg::*;

   localparam int IW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_EMIT    = 9'b000000010,
      S_INS_DL  = 9'b000000100,
      S_INS_CMP = 9'b000001000,
      S_INS_PUT = 9'b000010000,
      S_RM_CMP  = 9'b000100000,
      S_RM_MOVE = 9'b001000000,
      S_CHK_DL  = 9'b010000000,
      S_CHK_CMP = 9'b100000000
   } state_type;

   function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
      ptr_inc = (p == IW'(DEPTH - 1)) ? '0 : p + IW'(1);
   endfunction

   function automatic logic [IW-1:0] ptr_dec(input logic [IW-1:0] p);
      ptr_dec = (p == '0) ? IW'(DEPTH - 1) : p - IW'(1);
   endfunction

   state_type            state_ff, state_in;
   logic [IW-1:0]        head_ff, head_in;
   logic [IW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [NUM_IDS-1:0]   flags_ff, flags_in;
   logic                 have_pend_ff, have_pend_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [IW-1:0]        ptr_ff, ptr_in;
   logic [IW-1:0]        hole_ff, hole_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [ID_W-1:0]      q_ff, q_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [TIME_W-1:0]    key_ff, key_in;
   logic [STAT_W-1:0]    res_status_ff, res_status_in;
   logic [ID_W-1:0]      res_id_ff, res_id_in;

   logic                 ord_we;
   logic [IW-1:0]        ord_waddr, ord_raddr;
   logic [ID_W-1:0]      ord_wdata, ord_rdata;
   logic                 dl_we;
   logic [ID_W-1:0]      dl_waddr, dl_raddr;
   logic [TIME_W-1:0]    dl_wdata, dl_rdata;

   logic                 out_free;
   logic [NUM_IDS-1:0]   req_bit, id_bit, q_bit;

   dotq_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_order_ram (
      .clock   (clock),
      .wr_en   (ord_we),
      .wr_addr (ord_waddr),
      .wr_data (ord_wdata),
      .rd_addr (ord_raddr),
      .rd_data (ord_rdata)
   );

   dotq_ram #(.WIDTH(TIME_W), .DEPTH(NUM_IDS)) u_deadline_ram (
      .clock   (clock),
      .wr_en   (dl_we),
      .wr_addr (dl_waddr),
      .wr_data (dl_wdata),
      .rd_addr (dl_raddr),
      .rd_data (dl_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign req_bit   = NUM_IDS'(1) << req_data.entry_id;
   assign id_bit    = NUM_IDS'(1) << id_ff;
   assign q_bit     = NUM_IDS'(1) << q_ff;

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      have_pend_in  = have_pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      ptr_in        = ptr_ff;
      hole_in       = hole_ff;
      k_in          = k_ff;
      q_in          = q_ff;
      id_in         = id_ff;
      key_in        = key_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      ord_we        = 1'b0;
      ord_waddr     = hole_ff;
      ord_wdata     = id_ff;
      ord_raddr     = head_ff;
      dl_we         = 1'b0;
      dl_waddr      = req_data.entry_id;
      dl_wdata      = req_data.deadline;
      dl_raddr      = q_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               id_in         = req_data.entry_id;
               res_id_in     = req_data.entry_id;
               res_status_in = STAT_DONE;
               state_in      = S_EMIT;
               unique case (req_data.opcode)
                  OP_INSERT: begin
                     if ((flags_ff & req_bit) != '0) begin
                        res_status_in = STAT_DUP;
                     end else if (count_ff >= CW'(DEPTH)) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        dl_we = 1'b1;
                        if (count_ff == '0) begin
                           ord_we    = 1'b1;
                           ord_waddr = tail_ff;
                           ord_wdata = req_data.entry_id;
                           tail_in   = ptr_inc(tail_ff);
                           count_in  = count_ff + CW'(1);
                           flags_in  = flags_ff | req_bit;
                        end else begin
                           hole_in   = tail_ff;
                           ptr_in    = ptr_dec(tail_ff);
                           ord_raddr = ptr_dec(tail_ff);
                           k_in      = count_ff;
                           key_in    = req_data.deadline;
                           state_in  = S_INS_DL;
                        end
                     end
                  end
                  OP_REMOVE: begin
                     if ((flags_ff & req_bit) == '0) begin
                        res_status_in = STAT_ABSENT;
                     end else begin
                        ptr_in    = head_ff;
                        ord_raddr = head_ff;
                        state_in  = S_RM_CMP;
                     end
                  end
                  OP_CHECK: begin
                     res_id_in     = '0;
                     res_status_in = STAT_NONE;
                     have_pend_in  = 1'b0;
                     if (count_ff != '0) begin
                        key_in    = req_data.now;
                        ord_raddr = head_ff;
                        state_in  = S_CHK_DL;
                     end
                  end
                  default: begin
                     res_id_in = '0;
                  end
               endcase
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = res_status_ff;
               rsp_data_in.result_id = res_id_ff;
               rsp_data_in.last      = 1'b1;
               state_in              = S_IDLE;
            end
         end
         S_INS_DL: begin
            q_in     = ord_rdata;
            dl_raddr = ord_rdata;
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            ord_we = 1'b1;
            if (key_ff < dl_rdata) begin
               ord_wdata = q_ff;
               hole_in   = ptr_ff;
               k_in      = k_ff - CW'(1);
               if (k_ff == CW'(1)) begin
                  state_in = S_INS_PUT;
               end else begin
                  ptr_in    = ptr_dec(ptr_ff);
                  ord_raddr = ptr_dec(ptr_ff);
                  state_in  = S_INS_DL;
               end
            end else begin
               tail_in  = ptr_inc(tail_ff);
               count_in = count_ff + CW'(1);
               flags_in = flags_ff | id_bit;
               state_in = S_EMIT;
            end
         end
         S_INS_PUT: begin
            ord_we   = 1'b1;
            tail_in  = ptr_inc(tail_ff);
            count_in = count_ff + CW'(1);
            flags_in = flags_ff | id_bit;
            state_in = S_EMIT;
         end
         S_RM_CMP: begin
            if (ord_rdata == id_ff) begin
               if (ptr_inc(ptr_ff) == tail_ff) begin
                  tail_in  = ptr_ff;
                  count_in = count_ff - CW'(1);
                  flags_in = flags_ff & ~id_bit;
                  state_in = S_EMIT;
               end else begin
                  hole_in   = ptr_ff;
                  ptr_in    = ptr_inc(ptr_ff);
                  ord_raddr = ptr_inc(ptr_ff);
                  state_in  = S_RM_MOVE;
               end
            end else begin
               ptr_in    = ptr_inc(ptr_ff);
               ord_raddr = ptr_inc(ptr_ff);
            end
         end
         S_RM_MOVE: begin
            ord_we    = 1'b1;
            ord_wdata = ord_rdata;
            hole_in   = ptr_ff;
            if (ptr_inc(ptr_ff) == tail_ff) begin
               tail_in  = ptr_ff;
               count_in = count_ff - CW'(1);
               flags_in = flags_ff & ~id_bit;
               state_in = S_EMIT;
            end else begin
               ptr_in    = ptr_inc(ptr_ff);
               ord_raddr = ptr_inc(ptr_ff);
            end
         end
         S_CHK_DL: begin
            q_in     = ord_rdata;
            dl_raddr = ord_rdata;
            state_in = S_CHK_CMP;
         end
         S_CHK_CMP: begin
            if (key_ff >= dl_rdata) begin
               if (!have_pend_ff || out_free) begin
                  if (have_pend_ff) begin
                     rsp_valid_in          = 1'b1;
                     rsp_data_in.status    = STAT_EXPIRED;
                     rsp_data_in.result_id = res_id_ff;
                     rsp_data_in.last      = 1'b0;
                  end
                  res_status_in = STAT_EXPIRED;
                  res_id_in     = q_ff;
                  have_pend_in  = 1'b1;
                  head_in       = ptr_inc(head_ff);
                  count_in      = count_ff - CW'(1);
                  flags_in      = flags_ff & ~q_bit;
                  if (count_ff == CW'(1)) begin
                     state_in = S_EMIT;
                  end else begin
                     ord_raddr = ptr_inc(head_ff);
                     state_in  = S_CHK_DL;
                  end
               end
            end else begin
               state_in = S_EMIT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         flags_ff     <= '0;
         have_pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         have_pend_ff <= have_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff   <= rsp_data_in;
      ptr_ff        <= ptr_in;
      hole_ff       <= hole_in;
      k_ff          <= k_in;
      q_ff          <= q_in;
      id_ff         <= id_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("pending count above depth");

   a_count_flags : assert property (@(posedge clock) disable iff (reset)
      count_ff == CW'($countones(flags_ff)))
      else $error("pending count disagrees with pending flags");

   a_chk_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHK_CMP) |-> (count_ff != '0))
      else $error("expiry compare on empty queue");

   a_mid_beat_expired : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.last) |-> (rsp_data_ff.status == STAT_EXPIRED))
      else $error("non-final beat that is not an expiry");

   a_full_no_insert : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS_DL) |-> (count_ff < CW'(DEPTH)))
      else $error("sorted insert started on a full queue");

endmodule

// File: dv/testbench.sv
// Self-checking bench for deadline_ordered_timer_queue: directed and random timer commands,
// predicted by a mirror of the sorted queue and checked beat by beat.
// Depends on dotq_pkg and the RTL of the block.
module testbench;
   import dotq_pkg::*;

   localparam int QUEUE_DEPTH = DEPTH_DEF;
   localparam int HOLD_CYCLES = 300;
   localparam int IDLE_LIMIT  = 4000;
   localparam int TAIL_CYCLES = 40;
   localparam logic [OP_W-1:0]   OP_UNUSED = 2'd3;
   localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [ID_W-1:0]   mirror_order[$];
   logic [TIME_W-1:0] mirror_deadline[NUM_IDS];
   logic [NUM_IDS-1:0] mirror_pending = '0;
   rsp_type           awaited_beats[$];

   int   mismatches  = 0;
   int   burst_left  = 0;
   int   idle_cycles = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen   = 1'b0;
   int   hold_left   = 0;
   int   stall_left  = 0;
   int   run_left    = 0;

   deadline_ordered_timer_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic rsp_type beat_of(input logic [STAT_W-1:0] st, input logic [ID_W-1:0] id,
                                       input logic lst);
      rsp_type b;
      b.status    = st;
      b.result_id = id;
      b.last      = lst;
      return b;
   endfunction

   task automatic advance_queue_model(input req_type cmd);
      rsp_type beats[$];
      int      pos;
      case (cmd.opcode)
         OP_INSERT: begin
            if (mirror_pending[cmd.entry_id]) begin
               beats.push_back(beat_of(STAT_DUP, cmd.entry_id, 1'b1));
            end else if (mirror_order.size() >= QUEUE_DEPTH) begin
               beats.push_back(beat_of(STAT_FULL, cmd.entry_id, 1'b1));
            end else begin
               pos = mirror_order.size();
               while (pos > 0 && cmd.deadline < mirror_deadline[mirror_order[pos-1]]) pos--;
               mirror_order.insert(pos, cmd.entry_id);
               mirror_deadline[cmd.entry_id] = cmd.deadline;
               mirror_pending[cmd.entry_id]  = 1'b1;
               beats.push_back(beat_of(STAT_DONE, cmd.entry_id, 1'b1));
            end
         end
         OP_REMOVE: begin
            if (!mirror_pending[cmd.entry_id]) begin
               beats.push_back(beat_of(STAT_ABSENT, cmd.entry_id, 1'b1));
            end else begin
               pos = -1;
               foreach (mirror_order[i]) if (pos < 0 && mirror_order[i] == cmd.entry_id) pos = i;
               if (pos >= 0) mirror_order.delete(pos);
               mirror_pending[cmd.entry_id] = 1'b0;
               beats.push_back(beat_of(STAT_DONE, cmd.entry_id, 1'b1));
            end
         end
         OP_CHECK: begin
            while (mirror_order.size() > 0 && cmd.now >= mirror_deadline[mirror_order[0]]) begin
               beats.push_back(beat_of(STAT_EXPIRED, mirror_order[0], 1'b0));
               mirror_pending[mirror_order[0]] = 1'b0;
               void'(mirror_order.pop_front());
            end
            if (beats.size() == 0) beats.push_back(beat_of(STAT_NONE, '0, 1'b1));
            else beats[beats.size()-1].last = 1'b1;
         end
         default: begin
            beats.push_back(beat_of(STAT_DONE, '0, 1'b1));
         end
      endcase
      foreach (beats[i]) awaited_beats.push_back(beats[i]);
   endtask

   task automatic send_cmd(input req_type cmd);
      req_data  <= cmd;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_queue_model(cmd);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 10);
      end
   endtask

   function automatic req_type make_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                        input logic [TIME_W-1:0] dl,
                                        input logic [TIME_W-1:0] tnow);
      req_type c;
      c.opcode   = op;
      c.entry_id = id;
      c.deadline = dl;
      c.now      = tnow;
      return c;
   endfunction

   task automatic wait_all_returned();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_beats.size() != 0);
   endtask

   task automatic test_basic_ops();
      send_cmd(make_cmd(OP_CHECK,  4'd0,  '0,           '0));
      send_cmd(make_cmd(OP_REMOVE, 4'd5,  '0,           '0));
      send_cmd(make_cmd(OP_UNUSED, 4'd15, TIME_MAX,     TIME_MAX));
      send_cmd(make_cmd(OP_INSERT, 4'd0,  '0,           TIME_MAX));
      send_cmd(make_cmd(OP_INSERT, 4'd15, TIME_MAX,     '0));
      send_cmd(make_cmd(OP_INSERT, 4'd0,  64'd5,        '0));
      send_cmd(make_cmd(OP_INSERT, 4'd3,  64'd100,      '0));
      send_cmd(make_cmd(OP_INSERT, 4'd4,  64'd100,      '0));
      send_cmd(make_cmd(OP_INSERT, 4'd9,  64'd50,       '0));
      send_cmd(make_cmd(OP_INSERT, 4'd10, 64'd100,      '0));
      send_cmd(make_cmd(OP_CHECK,  4'd0,  '0,           '0));
      send_cmd(make_cmd(OP_CHECK,  4'd0,  '0,           64'd99));
      send_cmd(make_cmd(OP_REMOVE, 4'd4,  '0,           '0));
      send_cmd(make_cmd(OP_REMOVE, 4'd4,  '0,           '0));
      send_cmd(make_cmd(OP_CHECK,  4'd0,  '0,           64'd100));
      send_cmd(make_cmd(OP_CHECK,  4'd0,  '0,           TIME_MAX - 1));
      send_cmd(make_cmd(OP_CHECK,  4'd0,  '0,           TIME_MAX));
      send_cmd(make_cmd(OP_CHECK,  4'd0,  '0,           TIME_MAX));
      wait_all_returned();
   endtask

   task automatic test_full_queue();
      logic [TIME_W-1:0] base;
      base = {$urandom, $urandom} >> 1;
      for (int i = 0; i < NUM_IDS; i++)
         send_cmd(make_cmd(OP_INSERT, ID_W'(i), base + TIME_W'($urandom_range(0, 3)), '0));
      send_cmd(make_cmd(OP_INSERT, 4'd7, base, '0));
      send_cmd(make_cmd(OP_REMOVE, 4'd7, '0, '0));
      send_cmd(make_cmd(OP_INSERT, 4'd7, '0, '0));
      send_cmd(make_cmd(OP_CHECK,  4'd0, '0, TIME_MAX));
      send_cmd(make_cmd(OP_CHECK,  4'd0, '0, TIME_MAX));
      wait_all_returned();
   endtask

   task automatic test_receiver_holdoff();
      hold_toggle <= ~hold_toggle;
      for (int i = 0; i < 24; i++) begin
         if (i % 4 == 3) send_cmd(make_cmd(OP_CHECK, '0, '0, 64'd40));
         else send_cmd(make_cmd(OP_INSERT, ID_W'($urandom_range(0, 15)),
                                TIME_W'($urandom_range(0, 80)), '0));
      end
      wait_all_returned();
   endtask

   task automatic test_random_traffic(input int count);
      req_type           cmd;
      logic [TIME_W-1:0] time_base;
      int                pick;
      time_base = {$urandom, $urandom} >> 2;
      for (int n = 0; n < count; n++) begin
         cmd.entry_id = ID_W'($urandom_range(0, 15));
         cmd.deadline = {$urandom, $urandom};
         cmd.now      = {$urandom, $urandom};
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            cmd.opcode = OP_INSERT;
            case ($urandom_range(0, 9))
               0: ;
               1: cmd.deadline = TIME_MAX - TIME_W'($urandom_range(0, 3));
               2: cmd.deadline = TIME_W'($urandom_range(0, 3));
               default: cmd.deadline = time_base + TIME_W'($urandom_range(0, 48));
            endcase
         end else if (pick < 65) begin
            cmd.opcode = OP_REMOVE;
            if (mirror_order.size() > 0 && $urandom_range(0, 3) != 0)
               cmd.entry_id = mirror_order[$urandom_range(0, mirror_order.size() - 1)];
         end else if (pick < 95) begin
            cmd.opcode = OP_CHECK;
            case ($urandom_range(0, 9))
               0: ;
               1: cmd.now = TIME_MAX;
               2: cmd.now = '0;
               default: begin
                  time_base = time_base + TIME_W'($urandom_range(0, 24));
                  cmd.now   = time_base;
               end
            endcase
         end else begin
            cmd.opcode = OP_UNUSED;
         end
         send_cmd(cmd);
         if ($urandom_range(0, 59) == 0) wait_all_returned();
      end
      wait_all_returned();
   endtask

   always @(posedge clock) begin
      if (hold_toggle != hold_seen) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (run_left > 0) begin
            run_left--;
         end else begin
            stall_left = $urandom_range(0, 6);
            run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat status %0d id %0d last %0d",
                                      rsp_data.status, rsp_data.result_id, rsp_data.last));
         end else begin
            want = awaited_beats.pop_front();
            if (rsp_data.status != want.status)
               report_mismatch($sformatf("status %0d, want %0d", rsp_data.status, want.status));
            if (rsp_data.result_id != want.result_id)
               report_mismatch($sformatf("result_id %0d, want %0d",
                                         rsp_data.result_id, want.result_id));
            if (rsp_data.last != want.last)
               report_mismatch($sformatf("last %0d, want %0d", rsp_data.last, want.last));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_basic_ops();
      test_full_queue();
      test_receiver_holdoff();
      test_random_traffic(420);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (awaited_beats.size() != 0)
         report_mismatch($sformatf("%0d beats never arrived", awaited_beats.size()));
      if (mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
